// ===== hw/rtl/orf_pkg.sv =====
// Shared types, constants and helpers for the overwriting ring FIFO.
`default_nettype none
package orf_pkg;

    localparam int DEPTH      = 256;
    localparam int DATA_WIDTH = 32;
    localparam int PTR_W      = $clog2(DEPTH);
    localparam int CNT_W      = PTR_W + 1;

    typedef enum logic [1:0] {
        FUNC_PUT    = 2'd0,
        FUNC_GET    = 2'd1,
        FUNC_CLEAR  = 2'd2,
        FUNC_STATUS = 2'd3
    } func_t;

    typedef struct packed {
        logic                  we;
        logic [PTR_W-1:0]      waddr;
        logic [DATA_WIDTH-1:0] wdata;
        logic                  re;
        logic [PTR_W-1:0]      raddr;
    } mem_req_t;

    typedef struct packed {
        logic             done;
        logic             read_valid;
        logic [CNT_W-1:0] fill_count;
        logic [CNT_W-1:0] high_water;
        logic             is_full;
        logic             not_empty;
    } result_t;

    // Advance a pointer, wrapping at the capacity in use.
    function automatic logic [PTR_W-1:0] step_ptr(input logic [PTR_W-1:0] p,
                                                  input logic [CNT_W-1:0] cap);
        logic [CNT_W-1:0] n;
        n = {1'b0, p} + CNT_W'(1);
        if (n >= cap)
            return '0;
        return n[PTR_W-1:0];
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/overwriting_ring_fifo.sv =====
// Top level of the overwriting ring FIFO.
// Takes one command (put, get, clear, status) per clock: busy stays low, so a
// command is taken on every cycle with start high. Each command's result shows
// on the result ports for one cycle with done high, in the cycle after the
// command is taken; the result is registered, as is the storage RAM's read data. The
// receiver cannot stall and must capture each result when done is high.
// read_word is zero unless read_valid. A put into a full queue drops the
// oldest word. Write the capacity only between commands, and clear after it.
`default_nettype none
module overwriting_ring_fifo (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic [1:0]                     func,
    input  wire logic signed [31:0]             put_word,
    input  wire logic                           cfg_wr_en,
    input  wire logic [orf_pkg::CNT_W-1:0]      cfg_wr_data,
    output logic                                done,
    output logic signed [31:0]                  read_word,
    output logic                                read_valid,
    output logic [orf_pkg::CNT_W-1:0]           fill_count,
    output logic [orf_pkg::CNT_W-1:0]           high_water,
    output logic                                is_full,
    output logic                                not_empty
);

    orf_pkg::mem_req_t                 mem_req;
    orf_pkg::result_t                  result;
    logic [orf_pkg::DATA_WIDTH-1:0]    ram_rdata;
    logic                              accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    orf_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .func        (func),
        .put_word    (put_word[orf_pkg::DATA_WIDTH-1:0]),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .mem_req     (mem_req),
        .result      (result)
    );

    orf_ram #(
        .WORDS (orf_pkg::DEPTH),
        .WIDTH (orf_pkg::DATA_WIDTH)
    ) u_ram (
        .clk   (clk),
        .we    (mem_req.we),
        .waddr (mem_req.waddr),
        .wdata (mem_req.wdata),
        .re    (mem_req.re),
        .raddr (mem_req.raddr),
        .rdata (ram_rdata)
    );

    assign done       = result.done;
    assign read_valid = result.read_valid;
    assign read_word  = result.read_valid ? 32'(signed'(ram_rdata)) : '0;
    assign fill_count = result.fill_count;
    assign high_water = result.high_water;
    assign is_full    = result.is_full;
    assign not_empty  = result.not_empty;

endmodule
`default_nettype wire

// ===== hw/rtl/orf_ram.sv =====
// Single-port-write, single-port-read synchronous RAM with registered read data.
`default_nettype none
module orf_ram #(
    parameter int WORDS = 256,
    parameter int WIDTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(WORDS)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(WORDS)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [WORDS];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
    end

    always_ff @(posedge clk)
    begin
        if (re)
            rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/orf_ctrl.sv =====
// Pointer, count and high-water control with the capacity register.
`default_nettype none
module orf_ctrl (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               accept,
    input  wire logic [1:0]                         func,
    input  wire logic [orf_pkg::DATA_WIDTH-1:0]     put_word,
    input  wire logic                               cfg_wr_en,
    input  wire logic [orf_pkg::CNT_W-1:0]          cfg_wr_data,
    output orf_pkg::mem_req_t                       mem_req,
    output orf_pkg::result_t                        result
);

    logic [orf_pkg::CNT_W-1:0] cap_reg;
    logic [orf_pkg::PTR_W-1:0] wptr_reg, wptr_next;
    logic [orf_pkg::PTR_W-1:0] rptr_reg, rptr_next;
    logic [orf_pkg::CNT_W-1:0] held_reg, held_next;
    logic [orf_pkg::CNT_W-1:0] peak_reg, peak_next;
    logic [orf_pkg::CNT_W-1:0] cap_eff;
    logic [orf_pkg::CNT_W:0]   held_inc;
    logic                      rd_ok;
    orf_pkg::result_t          result_reg, result_next;
    orf_pkg::func_t            op;

    assign op = orf_pkg::func_t'(func);

    always_comb
    begin
        if (cap_reg == '0)
            cap_eff = orf_pkg::CNT_W'(1);
        else if (cap_reg > orf_pkg::CNT_W'(orf_pkg::DEPTH))
            cap_eff = orf_pkg::CNT_W'(orf_pkg::DEPTH);
        else
            cap_eff = cap_reg;
    end

    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        held_next = held_reg;
        peak_next = peak_reg;
        rd_ok     = 1'b0;
        held_inc  = {1'b0, held_reg} + (orf_pkg::CNT_W + 1)'(1);

        mem_req.we    = 1'b0;
        mem_req.waddr = wptr_reg;
        mem_req.wdata = put_word;
        mem_req.re    = 1'b0;
        mem_req.raddr = rptr_reg;

        if (accept)
        begin
            case (op)
                orf_pkg::FUNC_PUT:
                begin
                    mem_req.we = 1'b1;
                    wptr_next  = orf_pkg::step_ptr(wptr_reg, cap_eff);
                    // full: oldest entry is overwritten, read side moves on
                    if (held_reg >= cap_eff)
                        rptr_next = orf_pkg::step_ptr(rptr_reg, cap_eff);
                    if (held_inc > {1'b0, cap_eff})
                        held_next = cap_eff;
                    else
                        held_next = held_inc[orf_pkg::CNT_W-1:0];
                    if (held_next > peak_reg)
                        peak_next = held_next;
                end
                orf_pkg::FUNC_GET:
                begin
                    if (held_reg != '0)
                    begin
                        rd_ok      = 1'b1;
                        mem_req.re = 1'b1;
                        rptr_next  = orf_pkg::step_ptr(rptr_reg, cap_eff);
                        held_next  = held_reg - orf_pkg::CNT_W'(1);
                    end
                end
                orf_pkg::FUNC_CLEAR:
                begin
                    wptr_next = '0;
                    rptr_next = '0;
                    held_next = '0;
                    peak_next = '0;
                end
                default:
                begin
                end
            endcase
        end

        result_next.done       = accept;
        result_next.read_valid = rd_ok;
        result_next.fill_count = held_next;
        result_next.high_water = peak_next;
        result_next.is_full    = (held_next >= cap_eff);
        result_next.not_empty  = (held_next != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg    <= orf_pkg::CNT_W'(orf_pkg::DEPTH);
            wptr_reg   <= '0;
            rptr_reg   <= '0;
            held_reg   <= '0;
            peak_reg   <= '0;
            result_reg <= '0;
        end
        else
        begin
            if (cfg_wr_en)
                cap_reg <= cfg_wr_data;
            wptr_reg   <= wptr_next;
            rptr_reg   <= rptr_next;
            held_reg   <= held_next;
            peak_reg   <= peak_next;
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/orf_checker.sv =====
// Port-level checks for the overwriting ring FIFO, bound to the top level.
`default_nettype none
module orf_checker (
    input wire logic                      clk,
    input wire logic                      rst_n,
    input wire logic                      start,
    input wire logic                      busy,
    input wire logic                      done,
    input wire logic signed [31:0]        read_word,
    input wire logic                      read_valid,
    input wire logic [orf_pkg::CNT_W-1:0] fill_count,
    input wire logic [orf_pkg::CNT_W-1:0] high_water,
    input wire logic                      is_full,
    input wire logic                      not_empty
);

    // every transfer in gives exactly one result on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> done)
        else $error("taken command produced no result");

    assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |=> !done)
        else $error("result without a command");

    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (not_empty == (fill_count != '0)) && (high_water >= fill_count))
        else $error("status fields inconsistent");

    assert property (@(posedge clk) disable iff (!rst_n)
        (done && is_full) |-> not_empty)
        else $error("full while empty");

    assert property (@(posedge clk) disable iff (!rst_n)
        (done && !read_valid) |-> (read_word == '0))
        else $error("read word not zero without valid data");

endmodule

bind overwriting_ring_fifo orf_checker u_orf_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .done       (done),
    .read_word  (read_word),
    .read_valid (read_valid),
    .fill_count (fill_count),
    .high_water (high_water),
    .is_full    (is_full),
    .not_empty  (not_empty)
);
`default_nettype wire

// ===== tb/overwriting_ring_fifo_tb.sv =====
// Self-checking testbench for the overwriting ring FIFO: random and directed commands.
`timescale 1ns / 100ps
module overwriting_ring_fifo_tb;

    localparam int CYCLE_LIMIT = 500000;
    localparam int ITEM_TARGET = 2000;

    typedef struct {
        logic [31:0]               word;
        logic                      valid;
        logic [orf_pkg::CNT_W-1:0] fill;
        logic [orf_pkg::CNT_W-1:0] peak;
        logic                      full;
        logic                      nonempty;
    } fifo_status_t;

    // Shadow copy of the queue plus the statuses still due from the block.
    class ring_fifo_scoreboard;
        logic [31:0]  slots [orf_pkg::DEPTH];
        int unsigned  wr_ptr;
        int unsigned  rd_ptr;
        int unsigned  held;
        int unsigned  peak;
        int unsigned  capacity;
        int           errors;
        fifo_status_t due_status [$];

        function new();
            wr_ptr   = 0;
            rd_ptr   = 0;
            held     = 0;
            peak     = 0;
            capacity = orf_pkg::DEPTH;
            errors   = 0;
        endfunction

        function void set_capacity(logic [orf_pkg::CNT_W-1:0] cap);
            capacity = 32'(cap);
        endfunction

        function int unsigned next_slot(int unsigned p, int unsigned cap);
            p = p + 1;
            return (p >= cap) ? 0 : p;
        endfunction

        function int outstanding();
            return due_status.size();
        endfunction

        function void take_command(orf_pkg::func_t f, logic [31:0] w);
            fifo_status_t s;
            int unsigned  cap;
            cap = capacity;
            if (cap == 0)
                cap = 1;
            if (cap > orf_pkg::DEPTH)
                cap = orf_pkg::DEPTH;
            s.word  = '0;
            s.valid = 1'b0;
            case (f)
                orf_pkg::FUNC_PUT:
                begin
                    slots[wr_ptr] = w;
                    wr_ptr = next_slot(wr_ptr, cap);
                    // full queue: oldest entry is dropped
                    if (held >= cap)
                        rd_ptr = next_slot(rd_ptr, cap);
                    held = held + 1;
                    if (held > cap)
                        held = cap;
                    if (held > peak)
                        peak = held;
                end
                orf_pkg::FUNC_GET:
                begin
                    if (held != 0)
                    begin
                        s.word  = slots[rd_ptr];
                        s.valid = 1'b1;
                        rd_ptr  = next_slot(rd_ptr, cap);
                        held    = held - 1;
                    end
                end
                orf_pkg::FUNC_CLEAR:
                begin
                    wr_ptr = 0;
                    rd_ptr = 0;
                    held   = 0;
                    peak   = 0;
                end
                default:
                begin
                end
            endcase
            s.fill     = held[orf_pkg::CNT_W-1:0];
            s.peak     = peak[orf_pkg::CNT_W-1:0];
            s.full     = (held >= cap);
            s.nonempty = (held != 0);
            due_status.push_back(s);
        endfunction

        function void compare(string field, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                $error("%s: expected %h, got %h", field, want, got);
                errors++;
            end
        endfunction

        function void check_status(logic [31:0] word, logic valid,
                                   logic [orf_pkg::CNT_W-1:0] fill,
                                   logic [orf_pkg::CNT_W-1:0] hw, logic full,
                                   logic nonempty);
            fifo_status_t s;
            if (due_status.size() == 0)
            begin
                $error("result strobe with no command outstanding");
                errors++;
                return;
            end
            s = due_status.pop_front();
            compare("read_word", s.word, word);
            compare("read_valid", 32'(s.valid), 32'(valid));
            compare("fill_count", 32'(s.fill), 32'(fill));
            compare("high_water", 32'(s.peak), 32'(hw));
            compare("is_full", 32'(s.full), 32'(full));
            compare("not_empty", 32'(s.nonempty), 32'(nonempty));
        endfunction
    endclass

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       start = 1'b0;
    logic                       busy;
    logic [1:0]                 func = orf_pkg::FUNC_STATUS;
    logic signed [31:0]         put_word = '0;
    logic                       cfg_wr_en = 1'b0;
    logic [orf_pkg::CNT_W-1:0]  cfg_wr_data = '0;
    logic                       done;
    logic signed [31:0]         read_word;
    logic                       read_valid;
    logic [orf_pkg::CNT_W-1:0]  fill_count;
    logic [orf_pkg::CNT_W-1:0]  high_water;
    logic                       is_full;
    logic                       not_empty;

    ring_fifo_scoreboard sb;
    int                  sent = 0;
    int                  cycle_count = 0;

    overwriting_ring_fifo uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .func        (func),
        .put_word    (put_word),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .done        (done),
        .read_word   (read_word),
        .read_valid  (read_valid),
        .fill_count  (fill_count),
        .high_water  (high_water),
        .is_full     (is_full),
        .not_empty   (not_empty)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Sample at the edge: transfers, register writes and result strobes.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_wr_en)
                sb.set_capacity(cfg_wr_data);
            if (start && !busy)
                sb.take_command(orf_pkg::func_t'(func), put_word);
            if (done)
                sb.check_status(read_word, read_valid, fill_count, high_water,
                                is_full, not_empty);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("** overwriting_ring_fifo: FAILED **");
            $finish;
        end
    end

    task automatic issue(orf_pkg::func_t f, logic [31:0] w);
        start    <= 1'b1;
        func     <= f;
        put_word <= w;
        do
            @(posedge clk);
        while (busy);
        sent++;
    endtask

    task automatic pause();
        int r;
        int n;
        r = $urandom_range(0, 99);
        if (r < 60)
            return;
        n = (r < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // Hold off until every status has come back.
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (sb.outstanding() != 0)
            @(posedge clk);
    endtask

    task automatic write_capacity(int cap);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= orf_pkg::CNT_W'(cap);
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 7))
            0: return 32'h0000_0000;
            1: return 32'hffff_ffff;
            2: return 32'h8000_0000;
            3: return 32'h7fff_ffff;
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        int             cap;
        int             len;
        int             put_pct;
        int             r;
        bit             burst;
        orf_pkg::func_t f;

        sb = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty behavior, word extremes, clear, smallest capacities
        issue(orf_pkg::FUNC_STATUS, 32'h0);
        issue(orf_pkg::FUNC_GET, 32'h0);
        issue(orf_pkg::FUNC_PUT, 32'h7fff_ffff);
        issue(orf_pkg::FUNC_PUT, 32'h8000_0000);
        issue(orf_pkg::FUNC_PUT, 32'h0000_0000);
        issue(orf_pkg::FUNC_PUT, 32'hffff_ffff);
        issue(orf_pkg::FUNC_STATUS, 32'h5555_5555);
        repeat (4) issue(orf_pkg::FUNC_GET, 32'haaaa_aaaa);
        issue(orf_pkg::FUNC_GET, 32'h0);
        issue(orf_pkg::FUNC_PUT, 32'h1234_5678);
        issue(orf_pkg::FUNC_CLEAR, 32'h0);
        issue(orf_pkg::FUNC_GET, 32'h0);
        issue(orf_pkg::FUNC_STATUS, 32'h0);
        drain();
        write_capacity(1);
        issue(orf_pkg::FUNC_CLEAR, 32'h0);
        issue(orf_pkg::FUNC_PUT, 32'hdead_beef);
        issue(orf_pkg::FUNC_PUT, 32'hcafe_f00d);
        issue(orf_pkg::FUNC_GET, 32'h0);
        issue(orf_pkg::FUNC_GET, 32'h0);
        drain();
        write_capacity(2);
        issue(orf_pkg::FUNC_CLEAR, 32'h0);
        repeat (3) issue(orf_pkg::FUNC_PUT, pick_word());
        repeat (2) issue(orf_pkg::FUNC_GET, 32'h0);
        drain();

        // fill every storage slot once so later capacity changes never read stale slots
        write_capacity(orf_pkg::DEPTH);
        issue(orf_pkg::FUNC_CLEAR, 32'h0);
        repeat (orf_pkg::DEPTH + 1)
        begin
            issue(orf_pkg::FUNC_PUT, pick_word());
            pause();
        end
        issue(orf_pkg::FUNC_STATUS, 32'h0);

        while (sent < ITEM_TARGET)
        begin
            drain();
            case ($urandom_range(0, 9))
                0: cap = 1;
                1: cap = orf_pkg::DEPTH;
                2, 3, 4, 5: cap = $urandom_range(2, 8);
                6, 7: cap = $urandom_range(9, 64);
                default: cap = $urandom_range(65, orf_pkg::DEPTH - 1);
            endcase
            write_capacity(cap);
            // mostly clear after a capacity change, sometimes carry the old state over
            if ($urandom_range(0, 3) != 0)
                issue(orf_pkg::FUNC_CLEAR, 32'h0);
            len = $urandom_range(30, 60);
            if ($urandom_range(0, 3) == 0)
                len = len + cap + cap / 2;
            put_pct = $urandom_range(20, 80);
            burst = ($urandom_range(0, 4) == 0);
            repeat (len)
            begin
                r = $urandom_range(0, 99);
                if (r < put_pct)
                    f = orf_pkg::FUNC_PUT;
                else if (r < 90)
                    f = orf_pkg::FUNC_GET;
                else if (r < 92)
                    f = orf_pkg::FUNC_CLEAR;
                else
                    f = orf_pkg::FUNC_STATUS;
                issue(f, pick_word());
                if (!burst)
                    pause();
            end
        end

        drain();
        repeat (4) @(posedge clk);
        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("** overwriting_ring_fifo: PASSED **");
        else
            $display("** overwriting_ring_fifo: FAILED **");
        $finish;
    end

endmodule
